/* rtl/imusc_pkg.sv */
// shared types and constants for the imu sample conditioner
package imusc_pkg;

    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_OFF_X    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_OFF_Y    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_OFF_Z    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_C_RECENT = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_C_OLDER  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_C_INPUT  = 3'd5;

    localparam logic signed [31:0] C_RECENT_RST = 32'sd2071735500;
    localparam logic signed [31:0] C_OLDER_RST  = -32'sd1000494912;
    localparam logic signed [31:0] C_INPUT_RST  = 32'sd2501237;

    // 0.0003 in q0.32
    localparam logic [20:0] CAL_GAIN = 21'd1288490;

    localparam int COEF_SHIFT = 30;
    localparam int CAL_SHIFT  = 32;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_CAL    = 1'b1;

    typedef struct packed {
        logic signed [31:0] c_recent;
        logic signed [31:0] c_older;
        logic signed [31:0] c_input;
    } coef_t;

    typedef struct packed {
        logic accept;
        logic cal;
        logic primed;
    } lane_ctl_t;

endpackage

/* rtl/imusc_lane.sv */
// one axis lane: gyro offset correction, offset calibration and accel iir filter
module imusc_lane
    import imusc_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 32
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  lane_ctl_t                      ctl,
    input  coef_t                          coef,
    input  logic                           off_wr,
    input  logic [31:0]                    off_data,
    input  logic signed [SAMPLE_WIDTH:0]   gyro_in,
    input  logic signed [SAMPLE_WIDTH-1:0] accel_in,
    output logic signed [SAMPLE_WIDTH-1:0] gyro_res,
    output logic signed [SAMPLE_WIDTH-1:0] accel_res
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int WW = SAMPLE_WIDTH + 40;

    typedef logic signed [WW-1:0] wide_t;

    localparam wide_t SAT_HI = {{(WW-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam wide_t SAT_LO = ~SAT_HI;

    function automatic logic signed [SW-1:0] sat(input wide_t v);
        logic signed [SW-1:0] r;
        if (v > SAT_HI)
        begin
            r = SAT_HI[SW-1:0];
        end
        else if (v < SAT_LO)
        begin
            r = SAT_LO[SW-1:0];
        end
        else
        begin
            r = v[SW-1:0];
        end
        return r;
    endfunction

    logic signed [SW-1:0] offset_reg, offset_next;
    logic signed [SW-1:0] last_gyro_reg, last_gyro_next;
    logic signed [SW-1:0] tap_oldest_reg, tap_oldest_next;
    logic signed [SW-1:0] tap_middle_reg, tap_middle_next;
    logic signed [SW-1:0] tap_newest_reg, tap_newest_next;

    logic signed [SW+31:0] p_recent;
    logic signed [SW+31:0] p_older;
    logic signed [SW+31:0] p_input;
    logic signed [SW+21:0] p_cal;
    wide_t                 acc;
    wide_t                 cal_q;
    logic signed [SW-1:0]  iir_val;
    logic signed [SW-1:0]  gyro_sum;
    logic signed [SW-1:0]  off_cal;
    logic signed [SW-1:0]  off_cfg;

    // filter step on the shifted taps
    assign p_recent = tap_newest_reg * coef.c_recent;
    assign p_older  = tap_middle_reg * coef.c_older;
    assign p_input  = accel_in * coef.c_input;
    assign acc      = wide_t'(p_recent) + wide_t'(p_older) + wide_t'(p_input)
                    + (wide_t'(1) <<< (COEF_SHIFT - 1));
    assign iir_val  = sat(acc >>> COEF_SHIFT);

    // calibration step
    assign p_cal    = last_gyro_reg * $signed({1'b0, CAL_GAIN});
    assign cal_q    = (wide_t'(p_cal) + (wide_t'(1) <<< (CAL_SHIFT - 1))) >>> CAL_SHIFT;
    assign off_cal  = sat(wide_t'(offset_reg) - cal_q);

    assign gyro_sum = sat(wide_t'(gyro_in) + wide_t'(offset_reg));
    assign off_cfg  = sat(wide_t'($signed(off_data)));

    assign gyro_res  = ctl.cal ? off_cal : gyro_sum;
    assign accel_res = ctl.primed ? iir_val : accel_in;

    always_comb
    begin
        offset_next     = offset_reg;
        last_gyro_next  = last_gyro_reg;
        tap_oldest_next = tap_oldest_reg;
        tap_middle_next = tap_middle_reg;
        tap_newest_next = tap_newest_reg;
        if (off_wr)
        begin
            offset_next = off_cfg;
        end
        else if (ctl.accept)
        begin
            if (ctl.cal)
            begin
                offset_next = off_cal;
            end
            else
            begin
                last_gyro_next = gyro_sum;
                if (ctl.primed)
                begin
                    tap_oldest_next = tap_middle_reg;
                    tap_middle_next = tap_newest_reg;
                    tap_newest_next = iir_val;
                end
                else
                begin
                    tap_oldest_next = accel_in;
                    tap_middle_next = accel_in;
                    tap_newest_next = accel_in;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg     <= '0;
            last_gyro_reg  <= '0;
            tap_oldest_reg <= '0;
            tap_middle_reg <= '0;
            tap_newest_reg <= '0;
        end
        else
        begin
            offset_reg     <= offset_next;
            last_gyro_reg  <= last_gyro_next;
            tap_oldest_reg <= tap_oldest_next;
            tap_middle_reg <= tap_middle_next;
            tap_newest_reg <= tap_newest_next;
        end
    end

`ifndef SYNTHESIS
    a_cal_keeps_filter: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.accept && ctl.cal && !off_wr) |=>
            ($stable(tap_newest_reg) && $stable(tap_middle_reg) && $stable(last_gyro_reg)))
        else $error("calibration item disturbed filter or gyro state");
    a_sample_shifts_taps: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.accept && !ctl.cal && ctl.primed && !off_wr) |=>
            (tap_middle_reg == $past(tap_newest_reg) && tap_oldest_reg == $past(tap_middle_reg)))
        else $error("filter taps did not shift on sample item");
`endif

endmodule

/* rtl/imusc_merge.sv */
// merge stage: assembles lane results into one item and buffers it with a skid slot
module imusc_merge
    import imusc_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 32
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  logic                              kind,
    input  logic [2:0][SAMPLE_WIDTH-1:0]      gyro_in,
    input  logic [2:0][SAMPLE_WIDTH-1:0]      accel_in,
    input  logic [2:0][SAMPLE_WIDTH-1:0]      mag_in,
    output logic                              full,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              is_offset,
    output logic [2:0][SAMPLE_WIDTH-1:0]      gyro_out,
    output logic [2:0][SAMPLE_WIDTH-1:0]      accel_out,
    output logic [2:0][SAMPLE_WIDTH-1:0]      mag_out
);

    typedef struct packed {
        logic                         is_off;
        logic [2:0][SAMPLE_WIDTH-1:0] gyro;
        logic [2:0][SAMPLE_WIDTH-1:0] accel;
        logic [2:0][SAMPLE_WIDTH-1:0] mag;
    } res_t;

    res_t new_res;
    res_t out_res_reg;
    res_t skid_res_reg;
    logic out_valid_reg;
    logic skid_valid_reg;
    logic take;
    logic load_out;
    logic load_skid;

    always_comb
    begin
        new_res.is_off = (kind == KIND_CAL);
        new_res.gyro   = gyro_in;
        new_res.accel  = (kind == KIND_CAL) ? '0 : accel_in;
        new_res.mag    = (kind == KIND_CAL) ? '0 : mag_in;
    end

    assign take      = out_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign load_out  = push && (!out_valid_reg || take);
    assign load_skid = push && out_valid_reg && !take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (take)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (push)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= load_skid;
            end
            else if (take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg && take)
        begin
            out_res_reg <= skid_res_reg;
        end
        else if (!skid_valid_reg && load_out)
        begin
            out_res_reg <= new_res;
        end
        if (!skid_valid_reg && load_skid)
        begin
            skid_res_reg <= new_res;
        end
    end

    assign out_valid = out_valid_reg;
    assign is_offset = out_res_reg.is_off;
    assign gyro_out  = out_res_reg.gyro;
    assign accel_out = out_res_reg.accel;
    assign mag_out   = out_res_reg.mag;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot holds an item while output is empty");
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !push)
        else $error("item pushed into full merge buffer");
    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && take) |=> (out_valid_reg && out_res_reg == $past(skid_res_reg)))
        else $error("skid item lost on drain");
`endif

endmodule

/* rtl/imusc_top_placeholder_unused.sv */
// axis remap helper: mount matrix turn of gyro and accel triples
module imusc_remap
    import imusc_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 32
)
(
    input  logic signed [SAMPLE_WIDTH-1:0] gyro_raw_x,
    input  logic signed [SAMPLE_WIDTH-1:0] gyro_raw_y,
    input  logic signed [SAMPLE_WIDTH-1:0] gyro_raw_z,
    input  logic signed [SAMPLE_WIDTH-1:0] accel_raw_x,
    input  logic signed [SAMPLE_WIDTH-1:0] accel_raw_y,
    input  logic signed [SAMPLE_WIDTH-1:0] accel_raw_z,
    output logic signed [SAMPLE_WIDTH:0]   gyro_turn [3],
    output logic signed [SAMPLE_WIDTH-1:0] accel_turn [3]
);

    localparam logic signed [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] S_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

    // x' = -y, y' = x, z' = z
    assign gyro_turn[0]  = -(SAMPLE_WIDTH+1)'(gyro_raw_y);
    assign gyro_turn[1]  = (SAMPLE_WIDTH+1)'(gyro_raw_x);
    assign gyro_turn[2]  = (SAMPLE_WIDTH+1)'(gyro_raw_z);
    assign accel_turn[0] = (accel_raw_y == S_MIN) ? S_MAX : -accel_raw_y;
    assign accel_turn[1] = accel_raw_x;
    assign accel_turn[2] = accel_raw_z;

endmodule

/* rtl/imu_sample_conditioner_core.sv */
// top level of the imu sample conditioner: config registers, three axis lanes and merge
//
//  channel  handshake              payload
//  in       in_valid / in_stall    kind, gyro_raw_*, accel_raw_*, mag_raw_*
//  out      out_valid / out_stall  is_offset, gyro_*, accel_*, mag_*
//  cfg      cfg_we                 cfg_index, cfg_data
//
// one item per cycle while in_stall is low; an accepted item is registered in the merge
// stage, and the single iir step per axis (three products and a sum) closes each lane's loop
// reset clears lane state to zero, coefficients to their defaults and the filter to unseeded
// the output register plus one skid slot let an item enter while a result waits;
// in_stall rises only when both are full
module imu_sample_conditioner_core
    import imusc_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 32
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           kind,
    input  logic signed [SAMPLE_WIDTH-1:0] gyro_raw_x,
    input  logic signed [SAMPLE_WIDTH-1:0] gyro_raw_y,
    input  logic signed [SAMPLE_WIDTH-1:0] gyro_raw_z,
    input  logic signed [SAMPLE_WIDTH-1:0] accel_raw_x,
    input  logic signed [SAMPLE_WIDTH-1:0] accel_raw_y,
    input  logic signed [SAMPLE_WIDTH-1:0] accel_raw_z,
    input  logic signed [SAMPLE_WIDTH-1:0] mag_raw_x,
    input  logic signed [SAMPLE_WIDTH-1:0] mag_raw_y,
    input  logic signed [SAMPLE_WIDTH-1:0] mag_raw_z,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           is_offset,
    output logic signed [SAMPLE_WIDTH-1:0] gyro_x,
    output logic signed [SAMPLE_WIDTH-1:0] gyro_y,
    output logic signed [SAMPLE_WIDTH-1:0] gyro_z,
    output logic signed [SAMPLE_WIDTH-1:0] accel_x,
    output logic signed [SAMPLE_WIDTH-1:0] accel_y,
    output logic signed [SAMPLE_WIDTH-1:0] accel_z,
    output logic signed [SAMPLE_WIDTH-1:0] mag_x,
    output logic signed [SAMPLE_WIDTH-1:0] mag_y,
    output logic signed [SAMPLE_WIDTH-1:0] mag_z,
    input  logic                           cfg_we,
    input  logic [REG_IDX_W-1:0]           cfg_index,
    input  logic [31:0]                    cfg_data
);

    coef_t     coef_reg, coef_next;
    logic      primed_reg, primed_next;
    lane_ctl_t ctl;
    logic      accept;
    logic      merge_full;
    logic [2:0] off_wr;

    logic signed [SAMPLE_WIDTH:0]   gyro_turn [3];
    logic signed [SAMPLE_WIDTH-1:0] accel_turn [3];
    logic signed [SAMPLE_WIDTH-1:0] gyro_res [3];
    logic signed [SAMPLE_WIDTH-1:0] accel_res [3];

    logic [2:0][SAMPLE_WIDTH-1:0] m_gyro_in, m_accel_in, m_mag_in;
    logic [2:0][SAMPLE_WIDTH-1:0] m_gyro, m_accel, m_mag;

    assign in_stall = merge_full;
    assign accept   = in_valid && !merge_full;

    assign ctl.accept = accept;
    assign ctl.cal    = (kind == KIND_CAL);
    assign ctl.primed = primed_reg;

    always_comb
    begin
        coef_next = coef_reg;
        off_wr    = 3'b000;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_OFF_X:    off_wr[0] = 1'b1;
                REG_OFF_Y:    off_wr[1] = 1'b1;
                REG_OFF_Z:    off_wr[2] = 1'b1;
                REG_C_RECENT: coef_next.c_recent = $signed(cfg_data);
                REG_C_OLDER:  coef_next.c_older  = $signed(cfg_data);
                REG_C_INPUT:  coef_next.c_input  = $signed(cfg_data);
                default:      coef_next = coef_reg;
            endcase
        end
    end

    assign primed_next = primed_reg || (accept && kind == KIND_SAMPLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.c_recent <= C_RECENT_RST;
            coef_reg.c_older  <= C_OLDER_RST;
            coef_reg.c_input  <= C_INPUT_RST;
            primed_reg        <= 1'b0;
        end
        else
        begin
            coef_reg   <= coef_next;
            primed_reg <= primed_next;
        end
    end

    imusc_remap #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_remap (
        .gyro_raw_x  (gyro_raw_x),
        .gyro_raw_y  (gyro_raw_y),
        .gyro_raw_z  (gyro_raw_z),
        .accel_raw_x (accel_raw_x),
        .accel_raw_y (accel_raw_y),
        .accel_raw_z (accel_raw_z),
        .gyro_turn   (gyro_turn),
        .accel_turn  (accel_turn)
    );

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        imusc_lane #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH)
        ) u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .coef      (coef_reg),
            .off_wr    (off_wr[i]),
            .off_data  (cfg_data),
            .gyro_in   (gyro_turn[i]),
            .accel_in  (accel_turn[i]),
            .gyro_res  (gyro_res[i]),
            .accel_res (accel_res[i])
        );
        assign m_gyro_in[i]  = gyro_res[i];
        assign m_accel_in[i] = accel_res[i];
    end

    assign m_mag_in[0] = mag_raw_x;
    assign m_mag_in[1] = mag_raw_y;
    assign m_mag_in[2] = mag_raw_z;

    imusc_merge #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .kind      (kind),
        .gyro_in   (m_gyro_in),
        .accel_in  (m_accel_in),
        .mag_in    (m_mag_in),
        .full      (merge_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .is_offset (is_offset),
        .gyro_out  (m_gyro),
        .accel_out (m_accel),
        .mag_out   (m_mag)
    );

    assign gyro_x  = m_gyro[0];
    assign gyro_y  = m_gyro[1];
    assign gyro_z  = m_gyro[2];
    assign accel_x = m_accel[0];
    assign accel_y = m_accel[1];
    assign accel_z = m_accel[2];
    assign mag_x   = m_mag[0];
    assign mag_y   = m_mag[1];
    assign mag_z   = m_mag[2];

`ifndef SYNTHESIS
    a_primed_after_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && kind == KIND_SAMPLE) |=> primed_reg)
        else $error("filter not seeded after first sample item");
    a_cal_result_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_offset) |-> (accel_x == 0 && accel_y == 0 && accel_z == 0
            && mag_x == 0 && mag_y == 0 && mag_z == 0))
        else $error("calibration result carries sample fields");
`endif

endmodule
